FILE: src/radix2_fft_engine_macros.svh
// Assertion macros for the FFT engine.
`ifndef RADIX2_FFT_ENGINE_MACROS_SVH
`define RADIX2_FFT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset.
`define R2FFT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("r2fft assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define R2FFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("r2fft assertion failed");
`else
`define R2FFT_ASSERT_IMPL(lbl, ante, cons)
`define R2FFT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/r2fft_pkg.sv
package r2fft_pkg;

  localparam int LOG2_MAX_POINTS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int RES_BITS        = 26;
  localparam int MAX_POINTS      = 1 << LOG2_MAX_POINTS;
  localparam int ADDR_W          = LOG2_MAX_POINTS;
  localparam int TW_W            = LOG2_MAX_POINTS - 1;
  localparam int TW_DEPTH        = MAX_POINTS / 2;
  localparam int STG_W           = $clog2(LOG2_MAX_POINTS + 1);
  localparam int CFG_W           = 4;
  localparam int PT_W            = 2 * RES_BITS;
  localparam int PROD_W          = RES_BITS + 16;
  localparam int PSUM_W          = PROD_W + 1;
  localparam int T_W             = PSUM_W - 15;
  localparam int ABS_W           = T_W + 1;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef logic [31:0] tw_rom_t [TW_DEPTH];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_MEM,
    ST_RD_OUT,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_SUM,
    ST_BF_WA,
    ST_BF_WB
  } state_t;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_TOP,
    WSEL_BOT
  } wsel_t;

  typedef struct packed {
    logic              mem_we;
    wsel_t             wsel;
    logic [ADDR_W-1:0] waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [TW_W-1:0]   tw_idx;
    logic              mul_en;
    logic              sum_en;
    logic              out_load;
    logic              out_hit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [15:0] to_q15(longint v);
    longint mag;
    longint r;
    mag = (v < 0) ? -v : v;
    r = (mag + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    return 16'((v < 0) ? -r : r);
  endfunction

  // Shift-and-subtract quotient, used only while building the ROM.
  function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= 64'(den)) begin
        rem = rem - 64'(den);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Twiddles exp(-2*pi*i*k/MAX_POINTS), Taylor series in Q30, rounded to Q1.15.
  function automatic tw_rom_t build_tw();
    tw_rom_t rom;
    longint unsigned term;
    longint unsigned rr;
    longint cs;
    longint sn;
    longint cv;
    longint sv;
    longint ang;
    logic upper;
    for (int k = 0; k < TW_DEPTH; k++) begin
      upper = (k * 4 >= MAX_POINTS);
      rr = upper ? longint'(k - MAX_POINTS / 4) : longint'(k);
      ang = longint'((2 * PI_Q30 * rr + MAX_POINTS / 2) / MAX_POINTS);
      term = ONE_Q30;
      cs = longint'(ONE_Q30);
      sn = 0;
      for (int n = 1; n < 28; n++) begin
        term = div_small((term * longint'(ang)) >> 30, unsigned'(n));
        case (n & 3)
          1: sn = sn + longint'(term);
          2: cs = cs - longint'(term);
          3: sn = sn - longint'(term);
          default: cs = cs + longint'(term);
        endcase
      end
      cv = upper ? -sn : cs;
      sv = upper ? cs : sn;
      rom[k] = {to_q15(cv), to_q15(-sv)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw();

  function automatic logic signed [RES_BITS-1:0] sat_res(logic signed [ABS_W-1:0] v);
    logic signed [ABS_W-1:0] hi;
    logic signed [ABS_W-1:0] lo;
    hi = ABS_W'((64'sd1 <<< (RES_BITS - 1)) - 1);
    lo = -ABS_W'(64'sd1 <<< (RES_BITS - 1));
    if (v > hi) return hi[RES_BITS-1:0];
    if (v < lo) return lo[RES_BITS-1:0];
    return v[RES_BITS-1:0];
  endfunction

endpackage

FILE: src/r2fft_ctrl.sv
module r2fft_ctrl
  import r2fft_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [ADDR_W-1:0]        in_bin_index,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_log2_size,
  input  dp_stat_t                 stat,
  output ctrl_cmd_t                cmd
);

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   log2_r, log2_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [STG_W-1:0]   stage_r, stage_nxt;
  logic [TW_W-1:0]    bf_r, bf_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;
  logic               zero_r, zero_nxt;

  logic [ADDR_W-1:0]  ones;
  logic [ADDR_W-1:0]  mask;
  logic [ADDR_W-1:0]  cnt_eff;
  logic [ADDR_W-1:0]  rev;
  logic [ADDR_W-1:0]  load_addr;
  logic [ADDR_W-1:0]  jmask;
  logic [ADDR_W-1:0]  half;
  logic [ADDR_W-1:0]  bfx;
  logic [ADDR_W-1:0]  top;
  logic [ADDR_W-1:0]  bot;
  logic [ADDR_W-1:0]  twx;
  logic [CFG_W-1:0]   cfg_clamp;
  logic               accept;

  assign ones  = '1;
  assign mask  = ~(ones << log2_r);
  assign cnt_eff = done_r ? '0 : cnt_r;

  always_comb begin
    for (int i = 0; i < ADDR_W; i++) rev[i] = cnt_eff[ADDR_W-1-i];
  end
  assign load_addr = rev >> (CFG_W'(ADDR_W) - log2_r);

  // Butterfly addresses: insert a zero bit at the span position.
  assign jmask = ~(ones << (stage_r - STG_W'(1)));
  assign half  = ADDR_W'(1) << (stage_r - STG_W'(1));
  assign bfx   = ADDR_W'(bf_r);
  assign top   = ((bfx & ~jmask) << 1) | (bfx & jmask);
  assign bot   = top | half;
  assign twx   = (bfx & jmask) << (STG_W'(LOG2_MAX_POINTS) - stage_r);

  always_comb begin
    cfg_clamp = cfg_log2_size;
    if (cfg_clamp == '0) cfg_clamp = CFG_W'(1);
    if (cfg_clamp > CFG_W'(LOG2_MAX_POINTS)) cfg_clamp = CFG_W'(LOG2_MAX_POINTS);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      log2_r  <= CFG_W'(LOG2_MAX_POINTS < 10 ? LOG2_MAX_POINTS : 10);
      cnt_r   <= '0;
      done_r  <= 1'b0;
      stage_r <= '0;
      bf_r    <= '0;
      idx_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      log2_r  <= log2_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      stage_r <= stage_nxt;
      bf_r    <= bf_nxt;
      idx_r   <= idx_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    log2_nxt  = log2_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    stage_nxt = stage_r;
    bf_nxt    = bf_r;
    idx_nxt   = idx_r;
    zero_nxt  = zero_r;

    cmd          = '0;
    cmd.wsel     = WSEL_LOAD;
    cmd.raddr_a  = top;
    cmd.raddr_b  = bot;
    cmd.tw_idx   = twx[TW_W-1:0];
    cmd.waddr    = load_addr;
    cmd.out_hit  = !zero_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          log2_nxt = cfg_clamp;
          cnt_nxt  = '0;
          done_nxt = 1'b0;
        end
        if (accept) begin
          if (!in_kind) begin
            cmd.mem_we = 1'b1;
            done_nxt   = 1'b0;
            if (cnt_eff == mask) begin
              cnt_nxt   = '0;
              stage_nxt = STG_W'(1);
              bf_nxt    = '0;
              state_nxt = ST_BF_RD;
            end else begin
              cnt_nxt = cnt_eff + ADDR_W'(1);
            end
          end else if (done_r) begin
            idx_nxt   = in_bin_index & mask;
            zero_nxt  = 1'b0;
            state_nxt = ST_RD_MEM;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = ST_RD_OUT;
          end
        end
      end
      ST_RD_MEM: begin
        cmd.rd_en   = 1'b1;
        cmd.raddr_a = idx_r;
        state_nxt   = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_BF_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_BF_SUM;
      end
      ST_BF_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = ST_BF_WA;
      end
      ST_BF_WA: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WSEL_TOP;
        cmd.waddr  = top;
        state_nxt  = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = WSEL_BOT;
        cmd.waddr  = bot;
        state_nxt  = ST_BF_RD;
        if (bf_r == mask[ADDR_W-1:1]) begin
          bf_nxt = '0;
          if (CFG_W'(stage_r) == log2_r) begin
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            stage_nxt = stage_r + STG_W'(1);
          end
        end else begin
          bf_nxt = bf_r + TW_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/r2fft_dp.sv
module r2fft_dp
  import r2fft_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  ctrl_cmd_t                         cmd,
  output dp_stat_t                          stat,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_im,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [RES_BITS-1:0]        out_bin_re,
  output logic signed [RES_BITS-1:0]        out_bin_im,
  output logic                              out_ready_res
);

  logic [PT_W-1:0]           mem [MAX_POINTS];
  logic [PT_W-1:0]           rda_r;
  logic [PT_W-1:0]           rdb_r;
  logic [31:0]               tw_r;
  logic [PT_W-1:0]           wdata;

  logic signed [PROD_W-1:0]  p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [RES_BITS-1:0] top_re_r, top_im_r, bot_re_r, bot_im_r;

  logic signed [RES_BITS-1:0] a_re, a_im, b_re, b_im;
  logic signed [15:0]        w_re, w_im;
  logic signed [PSUM_W-1:0]  ps_re, ps_im;
  logic signed [T_W-1:0]     t_re, t_im;

  logic                      out_valid_r;
  logic signed [RES_BITS-1:0] out_re_r, out_im_r;
  logic                      out_rdy_r;

  assign a_re = rda_r[PT_W-1:RES_BITS];
  assign a_im = rda_r[RES_BITS-1:0];
  assign b_re = rdb_r[PT_W-1:RES_BITS];
  assign b_im = rdb_r[RES_BITS-1:0];
  assign w_re = tw_r[31:16];
  assign w_im = tw_r[15:0];

  always_comb begin
    case (cmd.wsel)
      WSEL_TOP: wdata = {top_re_r, top_im_r};
      WSEL_BOT: wdata = {bot_re_r, bot_im_r};
      default:  wdata = {{(RES_BITS-SAMPLE_BITS){in_sample_re[SAMPLE_BITS-1]}}, in_sample_re,
                         {(RES_BITS-SAMPLE_BITS){in_sample_im[SAMPLE_BITS-1]}}, in_sample_im};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[cmd.waddr] <= wdata;
    if (cmd.rd_en) begin
      rda_r <= mem[cmd.raddr_a];
      rdb_r <= mem[cmd.raddr_b];
      tw_r  <= TW_ROM[cmd.tw_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_rr_r <= PROD_W'(w_re) * PROD_W'(b_re);
      p_ii_r <= PROD_W'(w_im) * PROD_W'(b_im);
      p_ri_r <= PROD_W'(w_re) * PROD_W'(b_im);
      p_ir_r <= PROD_W'(w_im) * PROD_W'(b_re);
    end
  end

  // Round half up, then floor by the arithmetic shift.
  assign ps_re = PSUM_W'(p_rr_r) - PSUM_W'(p_ii_r) + PSUM_W'(16384);
  assign ps_im = PSUM_W'(p_ri_r) + PSUM_W'(p_ir_r) + PSUM_W'(16384);
  assign t_re  = ps_re[PSUM_W-1:15];
  assign t_im  = ps_im[PSUM_W-1:15];

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      top_re_r <= sat_res(ABS_W'(a_re) + ABS_W'(t_re));
      top_im_r <= sat_res(ABS_W'(a_im) + ABS_W'(t_im));
      bot_re_r <= sat_res(ABS_W'(a_re) - ABS_W'(t_re));
      bot_im_r <= sat_res(ABS_W'(a_im) - ABS_W'(t_im));
    end
  end

  // Output register: hold while stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_re_r  <= cmd.out_hit ? a_re : '0;
      out_im_r  <= cmd.out_hit ? a_im : '0;
      out_rdy_r <= cmd.out_hit;
    end
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_bin_re    = out_re_r;
  assign out_bin_im    = out_im_r;
  assign out_ready_res = out_rdy_r;

endmodule

FILE: src/radix2_fft_engine.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | in_kind, in_sample_re, in_sample_im, in_bin_index
// out     | out_valid / out_stall| out_bin_re, out_bin_im, out_ready_res
// cfg     | cfg_valid / cfg_ready| cfg_log2_size
//
// Each load writes one point; the load that completes a frame starts the transform,
// which runs on one shared butterfly (read, multiply, add, two writes through the
// single point memory write port). A read passes ST_RD_MEM, skipped while no finished
// transform is held, then ST_RD_OUT, which waits while the output register is held.
// Reset (rst_n low, synchronous) clears control state; point memory is not cleared.
// out_stall holds the output register; input is taken again while it is held.
`include "radix2_fft_engine_macros.svh"

module radix2_fft_engine
  import r2fft_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_im,
  input  logic [ADDR_W-1:0]             in_bin_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [RES_BITS-1:0]    out_bin_re,
  output logic signed [RES_BITS-1:0]    out_bin_im,
  output logic                          out_ready_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_log2_size
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  r2fft_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_bin_index  (in_bin_index),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_log2_size (cfg_log2_size),
    .stat          (stat),
    .cmd           (cmd)
  );

  r2fft_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_sample_re  (in_sample_re),
    .in_sample_im  (in_sample_im),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_re    (out_bin_re),
    .out_bin_im    (out_bin_im),
    .out_ready_res (out_ready_res)
  );

  `R2FFT_ASSERT_NEXT(a_read_leaves_idle, in_valid && !in_stall && in_kind, in_stall)
  `R2FFT_ASSERT_IMPL(a_miss_is_zero, out_valid && !out_ready_res, out_bin_re == '0 && out_bin_im == '0)
  `R2FFT_ASSERT_IMPL(a_load_when_free, cmd.out_load, !stat.out_busy)
  `R2FFT_ASSERT_IMPL(a_no_write_on_read, cmd.mem_we && cmd.rd_en, 1'b0)

endmodule
